// ----- rtl/core/dbu_pkg.sv -----
package dbu_pkg;

  // Slots in one bank window and columns in one phase group.
  localparam int unsigned BankSlots = 76;
  localparam int unsigned GroupCols = 19;

  // Width used for window compares (positions up to 1023, window ends up to 587).
  localparam int unsigned CmpW = 11;

  // Configuration register indexes.
  localparam logic [2:0] RegBankOne     = 3'd0;
  localparam logic [2:0] RegBankTwo     = 3'd1;
  localparam logic [2:0] RegBankThree   = 3'd2;
  localparam logic [2:0] RegBankFour    = 3'd3;
  localparam logic [2:0] RegAnalogRot   = 3'd4;
  localparam logic [2:0] RegDigitalRot  = 3'd5;
  localparam logic [2:0] RegDigitalMode = 3'd6;
  localparam logic [2:0] RegAnalogMode  = 3'd7;

  // Map mode codes.
  localparam logic [2:0] MapRegular  = 3'd0;
  localparam logic [2:0] MapReversed = 3'd1;
  localparam logic [2:0] MapShiftLo  = 3'd2;
  localparam logic [2:0] MapShiftHi  = 3'd5;

  // Result kinds.
  localparam logic KindAnalog  = 1'b0;
  localparam logic KindDigital = 1'b1;

  // Per-bank pixel bases for each write kind.
  localparam logic [3:0][8:0] AnalogBase  = {9'd0, 9'd152, 9'd76, 9'd228};
  localparam logic [3:0][8:0] DigitalBase = {9'd228, 9'd152, 9'd76, 9'd0};

  typedef struct packed {
    logic [3:0][8:0] bank_start;
    logic [6:0]      analog_rotate;
    logic [6:0]      digital_rotate;
    logic            digital_map_mode;
    logic [2:0]      analog_map_mode;
  } dbu_cfg_t;

  // Rotate a bank offset by a slot count; counts past the window act as zero.
  function automatic logic [6:0] rotate_slot(input logic [6:0] off, input logic [6:0] rot);
    logic [6:0] eff;
    logic [7:0] sum;
    eff = (rot > 7'(BankSlots - 1)) ? 7'd0 : rot;
    sum = {1'b0, off} + {1'b0, eff};
    if (sum >= 8'(BankSlots)) begin
      sum = sum - 8'(BankSlots);
    end
    return sum[6:0];
  endfunction

  // Scramble a slot to its pixel index within the bank.
  function automatic logic [6:0] map_slot(input logic [6:0] slot, input logic [2:0] mode);
    logic [1:0] g;
    logic [4:0] c;
    logic [1:0] grp;
    logic       shift;
    g     = slot[1:0];
    c     = slot[6:2];
    grp   = (mode == MapRegular) ? g : (2'd3 - g);
    shift = (mode >= MapShiftLo) && (mode <= MapShiftHi) && ({1'b0, g} == (mode - MapShiftLo));
    if (shift) begin
      c = (c >= 5'd2) ? (c - 5'd2) : (c + 5'(GroupCols - 2));
    end
    return 7'(7'(grp) * 7'(GroupCols)) + 7'(c);
  endfunction

endpackage

// ----- rtl/core/dbu_in_if.sv -----
interface dbu_in_if;
  import dbu_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic        end_of_packet;

  modport source (output valid, output packet_word, output end_of_packet, input ready);
  modport sink (input valid, input packet_word, input end_of_packet, output ready);
endinterface

// ----- rtl/core/dbu_out_if.sv -----
interface dbu_out_if;
  import dbu_pkg::*;

  logic        valid;
  logic        ready;
  logic        write_kind;
  logic [8:0]  pixel_address;
  logic [15:0] pixel_value;
  logic        gain_bit;
  logic        last_of_run;

  modport source (output valid, output write_kind, output pixel_address,
                  output pixel_value, output gain_bit, output last_of_run, input ready);
  modport sink (input valid, input write_kind, input pixel_address,
                input pixel_value, input gain_bit, input last_of_run, output ready);
endinterface

// ----- rtl/core/dbu_cfg_if.sv -----
interface dbu_cfg_if;
  import dbu_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/dbu_slot_map.sv -----
module dbu_slot_map
  import dbu_pkg::*;
(
  input  dbu_cfg_t   cfg,
  input  logic [1:0] bank,
  input  logic [6:0] offset,
  output logic [8:0] analog_address,
  output logic [8:0] digital_address
);

  logic [6:0] analog_slot;
  logic [6:0] digital_slot;
  logic [2:0] analog_mode;
  logic [6:0] analog_pixel;
  logic [6:0] digital_pixel;

  // Rotate the bank offset separately for each write kind.
  assign analog_slot  = rotate_slot(offset, cfg.analog_rotate);
  assign digital_slot = rotate_slot(offset, cfg.digital_rotate);

  // Undefined analog modes fall back to the plain reversed map.
  assign analog_mode = (cfg.analog_map_mode > MapShiftHi) ? MapReversed : cfg.analog_map_mode;

  assign analog_pixel  = map_slot(analog_slot, analog_mode);
  assign digital_pixel = map_slot(digital_slot, {2'b00, cfg.digital_map_mode});

  // Add the bank base for each kind.
  assign analog_address  = AnalogBase[bank] + 9'(analog_pixel);
  assign digital_address = DigitalBase[bank] + 9'(digital_pixel);

endmodule

// ----- rtl/core/detector_bank_unscrambler.sv -----
// Channel  Direction  Payload                                         Accepted when
// pkt      in         packet_word, end_of_packet                      valid && ready
// pix      out        write_kind, pixel_address, pixel_value,         valid && ready
//                     gain_bit, last_of_run
// cfg      in         index, data                                     valid && ready
//
// A word is held in the input register, then its two pixel writes sit in the
// result register and leave one per cycle while pix.ready is high, analog first.
// Inside a bank window the single result channel, which carries both writes,
// sets the sustained rate; words outside all windows drain at one per cycle.
// Reset (rst, synchronous) restores register defaults and clears the word position.
// A stalled result channel holds the result register; one more word waits in the
// input register before pkt.ready drops. cfg.ready is always high.
module detector_bank_unscrambler
  import dbu_pkg::*;
#(
  parameter int unsigned PACKET_WORDS = 512
) (
  input logic        clk,
  input logic        rst,
  dbu_in_if.sink     pkt,
  dbu_out_if.source  pix,
  dbu_cfg_if.sink    cfg
);

  localparam int unsigned PosW = $clog2(PACKET_WORDS);

  dbu_cfg_t cfg_regs;

  logic [PosW-1:0] word_position;
  logic [PosW:0]   position_inc;

  // Input register.
  logic        s1_valid;
  logic        s1_hit;
  logic [1:0]  s1_bank;
  logic [6:0]  s1_offset;
  logic [31:0] s1_word;

  // Result register holding both writes of one word.
  logic        pair_valid;
  logic        phase;
  logic [8:0]  analog_address;
  logic [15:0] analog_value;
  logic [8:0]  digital_address;
  logic [15:0] digital_value;
  logic        digital_gain;

  logic            in_fire;
  logic            pair_can_load;
  logic            s1_advance;
  logic            pair_load;
  logic            hit_next;
  logic [1:0]      bank_next;
  logic [6:0]      offset_next;
  logic [CmpW-1:0] pos_wide;
  logic [CmpW-1:0] start_wide;
  logic [CmpW-1:0] diff_wide;
  logic [8:0]      map_analog;
  logic [8:0]      map_digital;

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.bank_start       <= {9'd228, 9'd152, 9'd76, 9'd0};
      cfg_regs.analog_rotate    <= 7'd0;
      cfg_regs.digital_rotate   <= 7'd0;
      cfg_regs.digital_map_mode <= 1'b1;
      cfg_regs.analog_map_mode  <= 3'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegBankOne:     cfg_regs.bank_start[0]    <= cfg.data;
        RegBankTwo:     cfg_regs.bank_start[1]    <= cfg.data;
        RegBankThree:   cfg_regs.bank_start[2]    <= cfg.data;
        RegBankFour:    cfg_regs.bank_start[3]    <= cfg.data;
        RegAnalogRot:   cfg_regs.analog_rotate    <= cfg.data[6:0];
        RegDigitalRot:  cfg_regs.digital_rotate   <= cfg.data[6:0];
        RegDigitalMode: cfg_regs.digital_map_mode <= cfg.data[0];
        RegAnalogMode:  cfg_regs.analog_map_mode  <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  // Handshake control.
  assign pair_can_load = !pair_valid || (phase && pix.ready);
  assign s1_advance    = s1_valid && (!s1_hit || pair_can_load);
  assign pair_load     = s1_advance && s1_hit;
  assign pkt.ready     = !s1_valid || s1_advance;
  assign in_fire       = pkt.valid && pkt.ready;

  // Bank window search; the lowest-numbered matching bank wins.
  always_comb begin
    hit_next   = 1'b0;
    bank_next  = 2'd0;
    pos_wide   = CmpW'(word_position);
    start_wide = '0;
    for (int b = 3; b >= 0; b--) begin
      if ((pos_wide >= CmpW'(cfg_regs.bank_start[b])) &&
          (pos_wide < CmpW'(cfg_regs.bank_start[b]) + CmpW'(BankSlots))) begin
        hit_next  = 1'b1;
        bank_next = 2'(b);
      end
    end
    start_wide  = CmpW'(cfg_regs.bank_start[bank_next]);
    diff_wide   = pos_wide - start_wide;
    offset_next = diff_wide[6:0];
  end

  // Word position within the packet.
  assign position_inc = {1'b0, word_position} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
    end else if (in_fire) begin
      if (pkt.end_of_packet || (position_inc >= (PosW+1)'(PACKET_WORDS))) begin
        word_position <= '0;
      end else begin
        word_position <= position_inc[PosW-1:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.ready) begin
      s1_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hit    <= hit_next;
      s1_bank   <= bank_next;
      s1_offset <= offset_next;
      s1_word   <= pkt.packet_word;
    end
  end

  // Slot rotation and scramble maps.
  dbu_slot_map u_slot_map (
    .cfg             (cfg_regs),
    .bank            (s1_bank),
    .offset          (s1_offset),
    .analog_address  (map_analog),
    .digital_address (map_digital)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (pair_load) begin
      pair_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (pix.valid && pix.ready) begin
      if (phase) begin
        pair_valid <= 1'b0;
        phase      <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pair_load) begin
      analog_address  <= map_analog;
      analog_value    <= {2'b00, s1_word[13:8], s1_word[7:0]};
      digital_address <= map_digital;
      digital_value   <= {s1_word[29:24], s1_word[23:16], s1_word[15:14]};
      digital_gain    <= s1_word[31];
    end
  end

  assign pix.valid         = pair_valid;
  assign pix.write_kind    = phase ? KindDigital : KindAnalog;
  assign pix.pixel_address = phase ? digital_address : analog_address;
  assign pix.pixel_value   = phase ? digital_value : analog_value;
  assign pix.gain_bit      = phase ? digital_gain : 1'b0;
  assign pix.last_of_run   = phase;

`ifndef NO_ASSERTIONS
  // An accepted analog write is always followed by its digital partner.
  assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready && (pix.write_kind == KindAnalog)
    |=> pix.valid && (pix.write_kind == KindDigital))
    else $error("analog write not followed by digital write");

  // Every pixel address lies inside the frame.
  assert property (@(posedge clk) disable iff (rst)
    pix.valid |-> (pix.pixel_address < 9'd304))
    else $error("pixel address outside frame");

  // The word position never reaches the packet length.
  assert property (@(posedge clk) disable iff (rst)
    (PosW+1)'(word_position) < (PosW+1)'(PACKET_WORDS))
    else $error("word position out of range");

  // A word taken while the input register is full must replace a departing word.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && s1_valid |-> s1_advance)
    else $error("input register overwritten");
`endif

endmodule
